/* hw/rtl/stb_pkg.sv */
// types and codes shared by the timer bank cells and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

  localparam int ACT_W    = 3;
  localparam int INDEX_W  = 3;
  localparam int FIELD_W  = 32;  // width of interval, elapsed and next_remaining fields
  localparam int FIRED_W  = 8;   // timers shown in fired_mask
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 3'd0,
    ACT_START    = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_SET_IVAL = 3'd3,
    ACT_CLEAR    = 3'd4
  } act_t;

  // command broadcast to every cell for the whole pass
  typedef struct packed {
    act_t               action;
    logic [INDEX_W-1:0] index;
    logic               rep;
  } stb_cmd_t;

  // status token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic               any;
    logic [FIRED_W-1:0] fired;
  } stb_tok_t;

endpackage

`default_nettype wire

/* hw/rtl/stb_cell.sv */
// one timer of the bank: applies the broadcast command when the token passes,
// folds its fire bit and remaining time into the token. uses stb_pkg
`timescale 1ns / 1ps
`default_nettype none

module stb_cell
  import stb_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire stb_cmd_t              cmd,
  input  wire logic [TIME_WIDTH-1:0] ival,
  input  wire logic [TIME_WIDTH-1:0] el,
  input  wire stb_tok_t              tok_in,
  input  wire logic [TIME_WIDTH-1:0] best_in,
  output stb_tok_t                   tok_out,
  output logic [TIME_WIDTH-1:0]      best_out
);

  localparam logic [$clog2(FIRED_W)-1:0] FB = $clog2(FIRED_W)'(IDX % FIRED_W);

  logic [TIME_WIDTH-1:0] rem, rem_next;
  logic [TIME_WIDTH-1:0] rel, rel_next;
  logic                  rep, rep_next;
  logic                  en, en_next;
  logic                  hit;
  logic                  fire;
  stb_tok_t              tok_next;
  logic [TIME_WIDTH-1:0] best_next;

  assign hit = (int'(cmd.index) == IDX);

  always_comb begin
    rem_next = rem;
    rel_next = rel;
    rep_next = rep;
    en_next  = en;
    fire     = 1'b0;
    unique case (cmd.action)
      ACT_TICK: begin
        if (en) begin
          if (rem > el) begin
            rem_next = rem - el;
          end else begin
            fire     = 1'b1;
            rem_next = rel;
            if (!rep) en_next = 1'b0;
          end
        end
      end
      ACT_START: begin
        if (hit) begin
          rel_next = ival;
          rem_next = ival;
          rep_next = cmd.rep;
          en_next  = 1'b1;
        end
      end
      ACT_STOP: begin
        if (hit) en_next = 1'b0;
      end
      ACT_SET_IVAL: begin
        if (hit && rel != ival) begin
          rel_next = ival;
          if (en) rem_next = ival;
        end
      end
      ACT_CLEAR: begin
        en_next = 1'b0;
      end
      default: begin
      end
    endcase

    tok_next       = tok_in;
    tok_next.any   = tok_in.any | fire;
    tok_next.found = tok_in.found | en_next;
    if (fire && IDX < FIRED_W) tok_next.fired[FB] = 1'b1;
    best_next = best_in;
    if (en_next && (!tok_in.found || rem_next < best_in)) best_next = rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem           <= '0;
      rel           <= '0;
      rep           <= 1'b0;
      en            <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        rem <= rem_next;
        rel <= rel_next;
        rep <= rep_next;
        en  <= en_next;
        // token payload carries no reset
        tok_out.found <= tok_next.found;
        tok_out.any   <= tok_next.any;
        tok_out.fired <= tok_next.fired;
        best_out      <= best_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/software_timer_bank.sv */
// bank of countdown timers built as a chain of timer cells
// top level; uses stb_pkg and stb_cell
//
// usage: one beat on the s_axis side carries one action (tuser) and its
// operands (tdata). tick counts every enabled timer down by elapsed and fires
// those that run out; start, stop and set interval address one timer; clear
// all disables every timer. every input beat gives exactly one m_axis beat
// with the fired mask and the smallest remaining time over enabled timers.
// a status token walks the chain of NUM_TIMERS cells, one cell per cycle, so
// an input beat yields its result once the token has passed the launch register
// and every cell, and no new beat is taken until the token has left the chain.
// the result sits in an output register with a one-deep spare slot behind it,
// so the next beat is accepted while a result still waits; tready is low while
// a token walks the chain and while the spare slot is full. a stalled receiver
// holds tvalid and tdata steady.
// reset (rst, synchronous) disables all timers, zeroes their times and
// empties the chain and the output slots; the block is ready the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = 8,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // timer_index[2:0], interval_value[34:3], repeat_mode[35], elapsed[67:36], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action[2:0]
  input  wire logic [ACT_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // fired_mask[7:0], any_fired[8], next_remaining[40:9], none_active[41], zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  typedef struct packed {
    logic               none;
    logic [FIELD_W-1:0] next;
    logic               any;
    logic [FIRED_W-1:0] fired;
  } res_t;

  localparam int RES_W = $bits(res_t);

  logic                  busy;
  logic                  launch;
  stb_cmd_t              cmd;
  logic [TIME_WIDTH-1:0] ival;
  logic [TIME_WIDTH-1:0] el;

  stb_tok_t              tok  [NUM_TIMERS+1];
  logic [TIME_WIDTH-1:0] best [NUM_TIMERS+1];
  logic [NUM_TIMERS:0]   chain_valid;

  logic in_beat;
  logic out_beat;
  logic done;
  res_t res_new;
  res_t out_res;
  res_t hold_res;
  logic out_valid;
  logic hold_valid;

  assign s_axis_tready = !busy && !hold_valid;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign out_beat      = out_valid && m_axis_tready;
  assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), out_res};

  // accept and broadcast registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
    end else begin
      launch <= in_beat;
      if (in_beat) busy <= 1'b1;
      else if (done) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd.action <= act_t'(s_axis_tuser);
      cmd.index  <= s_axis_tdata[2:0];
      cmd.rep    <= s_axis_tdata[35];
      ival       <= TIME_WIDTH'(s_axis_tdata[34:3]);
      el         <= TIME_WIDTH'(s_axis_tdata[67:36]);
    end
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
    best[0]      = '0;
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    stb_cell #(
      .IDX        (i),
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .ival     (ival),
      .el       (el),
      .tok_in   (tok[i]),
      .best_in  (best[i]),
      .tok_out  (tok[i+1]),
      .best_out (best[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= NUM_TIMERS; k++) chain_valid[k] = tok[k].valid;
  end

  assign done          = tok[NUM_TIMERS].valid;
  assign res_new.fired = tok[NUM_TIMERS].fired;
  assign res_new.any   = tok[NUM_TIMERS].any;
  assign res_new.next  = tok[NUM_TIMERS].found ? FIELD_W'(best[NUM_TIMERS]) : '0;
  assign res_new.none  = !tok[NUM_TIMERS].found;

  // output register plus one spare slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      priority if (out_beat && hold_valid) begin
        out_res <= hold_res;
        if (done) hold_res <= res_new;
        else hold_valid <= 1'b0;
      end else if (!out_valid || out_beat) begin
        out_valid <= done;
        if (done) out_res <= res_new;
      end else begin
        if (done) begin
          hold_res   <= res_new;
          hold_valid <= 1'b1;
        end
      end
    end
  end

  // at most one token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_valid) <= 1)
    else $error("more than one token in the cell chain");

  // result arrives once the token has passed the launch register and every cell
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> ##(NUM_TIMERS+1) done)
    else $error("token did not reach the chain end in time");

  a_hold_order: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("spare slot full while output register empty");

  a_room: assert property (@(posedge clk) disable iff (rst)
    done |-> !hold_valid)
    else $error("result finished with no free slot");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.none |-> out_res.next == '0)
    else $error("next_remaining nonzero with no timer enabled");

endmodule

`default_nettype wire
